// File: hdl/isl_pkg.sv
// shared types and constants for the indexed shift list
`timescale 1ns / 1ps

package isl_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_WIDTH    = 32;
   localparam int FUNC_WIDTH    = 3;
   localparam int POS_WIDTH     = 5;
   localparam int STATUS_WIDTH  = 2;
   localparam int COUNT_WIDTH   = 5;

   localparam logic [FUNC_WIDTH-1:0] FN_SET    = 3'd0;
   localparam logic [FUNC_WIDTH-1:0] FN_GET    = 3'd1;
   localparam logic [FUNC_WIDTH-1:0] FN_INSERT = 3'd2;
   localparam logic [FUNC_WIDTH-1:0] FN_REMOVE = 3'd3;
   localparam logic [FUNC_WIDTH-1:0] FN_PUSH   = 3'd4;
   localparam logic [FUNC_WIDTH-1:0] FN_POP    = 3'd5;

   localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd3;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_SHIFT_UP,
      CELL_SHIFT_DOWN
   } cell_op_type;

   typedef struct packed {
      cell_op_type                   op;
      logic signed [DATA_WIDTH-1:0] data;
   } cell_ctrl_type;

endpackage

// File: hdl/isl_cell.sv
// one list entry: holds a word, loads it or takes it from a neighbor
`timescale 1ns / 1ps

module isl_cell #(
   parameter int IW    = 4,
   parameter int INDEX = 0
) (
   input  logic                                 clock,
   input  isl_pkg::cell_ctrl_type               ctrl,
   input  logic [IW-1:0]                        pos,
   input  logic signed [isl_pkg::DATA_WIDTH-1:0] left_value,
   input  logic signed [isl_pkg::DATA_WIDTH-1:0] right_value,
   output logic signed [isl_pkg::DATA_WIDTH-1:0] value
);
   import isl_pkg::*;

   localparam logic [IW-1:0] MY_INDEX = IW'(INDEX);

   logic signed [DATA_WIDTH-1:0] value_ff;
   logic signed [DATA_WIDTH-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (ctrl.op)
         CELL_LOAD: begin
            if (MY_INDEX == pos) value_in = ctrl.data;
         end
         CELL_SHIFT_UP: begin
            if (MY_INDEX > pos) value_in = left_value;
            else if (MY_INDEX == pos) value_in = ctrl.data;
         end
         CELL_SHIFT_DOWN: begin
            if (MY_INDEX >= pos) value_in = right_value;
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// File: hdl/indexed_shift_list.sv
// top level of the indexed shift list: request decode, cell chain and result register
`timescale 1ns / 1ps

// A bounded ordered list of up to DEPTH signed 32-bit words supporting set, get,
// insert, remove, push and pop. One item is accepted per clock cycle and its
// result appears in the output register on the following cycle; every entry
// sits in its own cell, so an insert or remove shifts the tail at once, and a get
// reads through a DEPTH-wide select. The input is stalled only
// while a result waits in the output register and the result side stalls.
// Entries need no clearing after reset: the list starts empty.
module indexed_shift_list #(
   parameter int DEPTH = isl_pkg::DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [isl_pkg::FUNC_WIDTH-1:0]        req_func,
   input  logic [isl_pkg::POS_WIDTH-1:0]         req_position,
   input  logic signed [isl_pkg::DATA_WIDTH-1:0] req_data_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [isl_pkg::DATA_WIDTH-1:0] rsp_data_out,
   output logic [isl_pkg::STATUS_WIDTH-1:0]      rsp_status,
   output logic [isl_pkg::COUNT_WIDTH-1:0]       rsp_count
);
   import isl_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > POS_WIDTH) ? CW : POS_WIDTH;
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [CW-1:0]                count_ff;
   logic [CW-1:0]                count_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic signed [DATA_WIDTH-1:0] rsp_data_ff;
   logic [STATUS_WIDTH-1:0]      rsp_status_ff;
   logic [COUNT_WIDTH-1:0]       rsp_count_ff;

   logic                         accept;
   logic [XW-1:0]                pos_x;
   logic [XW-1:0]                count_x;
   logic                         in_range;
   logic                         ins_range;
   logic                         full;
   logic                         empty;
   cell_op_type                  op;
   logic                         use_count;
   logic [IW-1:0]                cell_pos;
   logic [IW-1:0]                pos_idx;
   logic [CW-1:0]                count_next;
   logic [STATUS_WIDTH-1:0]      status_next;
   logic signed [DATA_WIDTH-1:0] read_next;
   cell_ctrl_type                ctrl;
   logic signed [DATA_WIDTH-1:0] cell_value [DEPTH];

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign pos_x     = XW'(req_position);
   assign count_x   = XW'(count_ff);
   assign in_range  = pos_x < count_x;
   assign ins_range = pos_x <= count_x;
   assign full      = count_ff == FULL_COUNT;
   assign empty     = count_ff == '0;
   assign pos_idx   = IW'(pos_x);

   // request decode
   always_comb begin
      op          = CELL_HOLD;
      use_count   = 1'b0;
      count_next  = count_ff;
      status_next = ST_OK;
      read_next   = '0;
      case (req_func)
         FN_SET: begin
            if (in_range) op = CELL_LOAD;
            else status_next = ST_RANGE;
         end
         FN_GET: begin
            if (in_range) read_next = cell_value[pos_idx];
            else status_next = ST_RANGE;
         end
         FN_INSERT: begin
            if (!ins_range) status_next = ST_RANGE;
            else if (full) status_next = ST_FULL;
            else begin
               op         = CELL_SHIFT_UP;
               count_next = count_ff + 1'b1;
            end
         end
         FN_REMOVE: begin
            if (!in_range) status_next = ST_RANGE;
            else begin
               op         = CELL_SHIFT_DOWN;
               count_next = count_ff - 1'b1;
            end
         end
         FN_PUSH: begin
            if (full) status_next = ST_FULL;
            else begin
               op         = CELL_LOAD;
               use_count  = 1'b1;
               count_next = count_ff + 1'b1;
            end
         end
         FN_POP: begin
            if (empty) status_next = ST_EMPTY;
            else count_next = count_ff - 1'b1;
         end
         default: op = CELL_HOLD;
      endcase
   end

   assign cell_pos  = use_count ? IW'(count_x) : pos_idx;
   assign ctrl.op   = accept ? op : CELL_HOLD;
   assign ctrl.data = req_data_in;
   assign count_in  = accept ? count_next : count_ff;

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic signed [DATA_WIDTH-1:0] left_value;
         logic signed [DATA_WIDTH-1:0] right_value;
         if (gi == 0) begin : g_first
            assign left_value = cell_value[gi];
         end else begin : g_left
            assign left_value = cell_value[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_last
            assign right_value = cell_value[gi];
         end else begin : g_right
            assign right_value = cell_value[gi+1];
         end
         isl_cell #(
            .IW    (IW),
            .INDEX (gi)
         ) u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .pos         (cell_pos),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[gi])
         );
      end
   endgenerate

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         rsp_data_ff   <= read_next;
         rsp_status_ff <= status_next;
         rsp_count_ff  <= COUNT_WIDTH'(count_next);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_count    = rsp_count_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("element count beyond capacity");

   a_fail_keeps_count : assert property (@(posedge clock) disable iff (reset)
      accept && status_next != ST_OK |=> $stable(count_ff))
      else $error("failing item changed the count");

   a_insert_grows : assert property (@(posedge clock) disable iff (reset)
      accept && req_func == FN_INSERT && status_next == ST_OK
      |=> count_ff == CW'($past(count_ff) + 1'b1))
      else $error("insert did not grow the list");

   a_result_count : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff && rsp_count_ff == COUNT_WIDTH'(count_ff))
      else $error("reported count differs from stored count");

endmodule

// File: tb/sv/indexed_shift_list_test.sv
// self-checking testbench for the indexed shift list: directed table, then random items
`timescale 1ns / 1ps

module indexed_shift_list_test;
   import isl_pkg::*;

   localparam int LIST_DEPTH    = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS  = 1370;
   localparam int LONG_HOLD     = 120;
   localparam int STUCK_LIMIT   = 2000;
   localparam int DIRECTED_ROWS = 24;

   localparam logic [FUNC_WIDTH-1:0] FN_SPARE_LO = 3'd6;
   localparam logic [FUNC_WIDTH-1:0] FN_SPARE_HI = 3'd7;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] data_out;
      logic [STATUS_WIDTH-1:0]      status;
      logic [COUNT_WIDTH-1:0]       count;
   } list_result_type;

   typedef struct packed {
      logic [FUNC_WIDTH-1:0]        func;
      logic [POS_WIDTH-1:0]         position;
      logic signed [DATA_WIDTH-1:0] data;
      int                           copies;
      bit                           fixed;
      list_result_type              want;
   } script_row_type;

   // fixed rows carry the result read straight off the operation, the rest use the predictor
   localparam script_row_type DIRECTED_SCRIPT [DIRECTED_ROWS] = '{
      '{FN_GET,      5'd0,  32'h00000000, 1,  1'b1, '{32'h0, ST_RANGE, 5'd0}},
      '{FN_POP,      5'd0,  32'h00000000, 1,  1'b1, '{32'h0, ST_EMPTY, 5'd0}},
      '{FN_REMOVE,   5'd0,  32'h00000000, 1,  1'b1, '{32'h0, ST_RANGE, 5'd0}},
      '{FN_SET,      5'd0,  32'hffffffff, 1,  1'b1, '{32'h0, ST_RANGE, 5'd0}},
      '{FN_INSERT,   5'd1,  32'hffffffff, 1,  1'b1, '{32'h0, ST_RANGE, 5'd0}},
      '{FN_INSERT,   5'd0,  32'h7fffffff, 1,  1'b1, '{32'h0, ST_OK, 5'd1}},
      '{FN_PUSH,     5'd31, 32'h80000000, 1,  1'b1, '{32'h0, ST_OK, 5'd2}},
      '{FN_GET,      5'd1,  32'h00000000, 1,  1'b1, '{32'h80000000, ST_OK, 5'd2}},
      '{FN_SPARE_LO, 5'd31, 32'hffffffff, 1,  1'b1, '{32'h0, ST_OK, 5'd2}},
      '{FN_SPARE_HI, 5'd0,  32'h00000000, 1,  1'b1, '{32'h0, ST_OK, 5'd2}},
      '{FN_INSERT,   5'd1,  32'h55555555, 1,  1'b0, '0},
      '{FN_SET,      5'd2,  32'haaaaaaaa, 1,  1'b0, '0},
      '{FN_GET,      5'd31, 32'h00000000, 1,  1'b1, '{32'h0, ST_RANGE, 5'd3}},
      '{FN_INSERT,   5'd4,  32'h00000000, 1,  1'b1, '{32'h0, ST_RANGE, 5'd3}},
      '{FN_GET,      5'd2,  32'h00000000, 1,  1'b0, '0},
      '{FN_REMOVE,   5'd0,  32'h00000000, 1,  1'b0, '0},
      '{FN_PUSH,     5'd0,  32'h00000100, 14, 1'b0, '0},
      '{FN_PUSH,     5'd0,  32'h00000001, 1,  1'b1, '{32'h0, ST_FULL, 5'd16}},
      '{FN_INSERT,   5'd16, 32'h00000001, 1,  1'b1, '{32'h0, ST_FULL, 5'd16}},
      '{FN_INSERT,   5'd17, 32'h00000001, 1,  1'b1, '{32'h0, ST_RANGE, 5'd16}},
      '{FN_SET,      5'd15, 32'h7fffffff, 1,  1'b0, '0},
      '{FN_GET,      5'd15, 32'h00000000, 1,  1'b0, '0},
      '{FN_REMOVE,   5'd15, 32'h00000000, 1,  1'b0, '0},
      '{FN_POP,      5'd0,  32'h00000000, 1,  1'b0, '0}
   };

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [FUNC_WIDTH-1:0]          req_func = FN_SET;
   logic [POS_WIDTH-1:0]           req_position = '0;
   logic signed [DATA_WIDTH-1:0]   req_data_in = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic signed [DATA_WIDTH-1:0]   rsp_data_out;
   logic [STATUS_WIDTH-1:0]        rsp_status;
   logic [COUNT_WIDTH-1:0]         rsp_count;

   logic signed [DATA_WIDTH-1:0]   list_words [LIST_DEPTH];
   int                             list_len = 0;
   list_result_type                pending_results [$];
   int                             status_hits [4] = '{0, 0, 0, 0};
   int                             mismatches = 0;
   int                             results_checked = 0;
   int                             items_driven = 0;
   int                             stuck_cycles = 0;
   bit                             idling_on = 1'b1;
   bit                             long_hold_request = 1'b0;

   indexed_shift_list #(
      .DEPTH(LIST_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_position(req_position),
      .req_data_in(req_data_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data_out(rsp_data_out),
      .rsp_status(rsp_status),
      .rsp_count(rsp_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [STATUS_WIDTH-1:0] insert_word(
      input int at,
      input logic signed [DATA_WIDTH-1:0] value);
      if (at > list_len) return ST_RANGE;
      if (list_len >= LIST_DEPTH) return ST_FULL;
      for (int i = list_len; i > at; i--) list_words[i] = list_words[i-1];
      list_words[at] = value;
      list_len++;
      return ST_OK;
   endfunction

   function automatic logic [STATUS_WIDTH-1:0] remove_word(input int at);
      if (at >= list_len) return ST_RANGE;
      for (int i = at; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
      list_len--;
      return ST_OK;
   endfunction

   function automatic list_result_type list_update(input logic [FUNC_WIDTH-1:0] func,
                                                   input logic [POS_WIDTH-1:0] position,
                                                   input logic signed [DATA_WIDTH-1:0] data);
      list_result_type res;
      int              at;
      res = '0;
      at = int'(position);
      case (func)
         FN_SET: begin
            if (at < list_len) list_words[at] = data;
            else res.status = ST_RANGE;
         end
         FN_GET: begin
            if (at < list_len) res.data_out = list_words[at];
            else res.status = ST_RANGE;
         end
         FN_INSERT: res.status = insert_word(at, data);
         FN_REMOVE: res.status = remove_word(at);
         FN_PUSH:   res.status = insert_word(list_len, data);
         FN_POP: begin
            if (list_len == 0) res.status = ST_EMPTY;
            else res.status = remove_word(list_len - 1);
         end
         default: ;
      endcase
      res.count = COUNT_WIDTH'(list_len);
      status_hits[res.status]++;
      return res;
   endfunction

   task automatic offer_item(input logic [FUNC_WIDTH-1:0] func,
                             input logic [POS_WIDTH-1:0] position,
                             input logic signed [DATA_WIDTH-1:0] data,
                             input bit fixed, input list_result_type want);
      list_result_type predicted;
      req_valid    <= 1'b1;
      req_func     <= func;
      req_position <= position;
      req_data_in  <= data;
      do @(posedge clock); while (req_stall);
      predicted = list_update(func, position, data);
      pending_results.push_back(fixed ? want : predicted);
      items_driven++;
   endtask

   task automatic idle_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic report_mismatch(input string field, input longint want, input longint got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch in %s of result %0d: expected %0d, got %0d",
                  field, results_checked, want, got);
   endtask

   always @(posedge clock) begin : check_results
      list_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d arrived with no item pending (status %0d, count %0d)",
                        results_checked, rsp_status, rsp_count);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data_out !== want.data_out)
               report_mismatch("data_out", want.data_out, rsp_data_out);
            if (rsp_status !== want.status)
               report_mismatch("status", want.status, rsp_status);
            if (rsp_count !== want.count)
               report_mismatch("count", want.count, rsp_count);
         end
         results_checked++;
      end
   end

   initial begin : receiver
      forever begin
         @(posedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
   end

   initial begin : watchdog
      while (stuck_cycles < STUCK_LIMIT) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      logic [FUNC_WIDTH-1:0]        func;
      logic [POS_WIDTH-1:0]         position;
      logic signed [DATA_WIDTH-1:0] data;
      int                           random_items;
      int                           step;
      int                           pick;
      bit                           grow;
      random_items = 0;
      step = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_SCRIPT[r]) begin
         for (int k = 0; k < DIRECTED_SCRIPT[r].copies; k++) begin
            offer_item(DIRECTED_SCRIPT[r].func, DIRECTED_SCRIPT[r].position,
                       DIRECTED_SCRIPT[r].data + k, DIRECTED_SCRIPT[r].fixed,
                       DIRECTED_SCRIPT[r].want);
            if ($urandom_range(0, 5) == 0) idle_sender($urandom_range(1, 17));
         end
      end

      while (random_items < RANDOM_ITEMS) begin
         idling_on = (step < 900 || step >= 1100) && step < 1250;
         if (step == 300) long_hold_request = 1'b1;
         if (step == 700) begin
            req_valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
         end
         // alternate stretches that fill the list and stretches that drain it
         grow = ((step / 120) % 2) == 0;
         pick = $urandom_range(0, 99);
         if (pick < 3) func = pick[0] ? FN_SPARE_HI : FN_SPARE_LO;
         else if (pick < 20) func = FN_GET;
         else if (pick < 35) func = FN_SET;
         else if (pick < 55) func = grow ? FN_PUSH : FN_POP;
         else if (pick < 75) func = grow ? FN_INSERT : FN_REMOVE;
         else if (pick < 88) func = grow ? FN_POP : FN_PUSH;
         else func = grow ? FN_REMOVE : FN_INSERT;
         if ($urandom_range(0, 9) < 8) position = POS_WIDTH'($urandom_range(0, list_len));
         else position = POS_WIDTH'($urandom_range(0, 31));
         case ($urandom_range(0, 19))
            0: data = 32'h7fffffff;
            1: data = 32'h80000000;
            2: data = 32'hffffffff;
            3: data = 32'h00000000;
            default: data = $urandom;
         endcase
         offer_item(func, position, data, 1'b0, '0);
         if (func != FN_SPARE_LO && func != FN_SPARE_HI) random_items++;
         step++;
         if (idling_on && $urandom_range(0, 9) == 0) idle_sender($urandom_range(1, 17));
      end
      idling_on = 1'b0;
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      $display("%0d items driven (%0d directed rows), %0d results checked",
               items_driven, DIRECTED_ROWS, results_checked);
      $display("rejections seen: %0d out of range, %0d full, %0d empty",
               status_hits[ST_RANGE], status_hits[ST_FULL], status_hits[ST_EMPTY]);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("simulation failed");
      end
      $finish;
   end

endmodule
